/* src/assert_macros.svh */
// Assertion helpers shared by the files that check their own logic.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPR_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The condition must never be seen at a clock edge.
`define TPR_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* src/tpr_pkg.sv */
`default_nettype none

package tpr_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COORD_W    = 9;

	localparam logic [CFG_IDX_W-1:0] REG_ROTATION   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS = 3'd5;

	localparam logic [1:0]  RESET_ROTATION   = 2'd0;
	localparam logic [11:0] RESET_X_OFFSET   = 12'd155;
	localparam logic [15:0] RESET_X_SCALE    = 16'd5705;
	localparam logic [11:0] RESET_Y_OFFSET   = 12'd168;
	localparam logic [15:0] RESET_Y_SCALE    = 16'd8353;
	localparam logic [9:0]  RESET_WAIT_TICKS = 10'd8;

	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	localparam logic [7:0] CMD_CONV_X = 8'hD0;
	localparam logic [7:0] CMD_CONV_Y = 8'h90;

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_CMD     = 4'd1;
	localparam logic [3:0] PH_WAIT    = 4'd2;
	localparam logic [3:0] PH_BUSY_LO = 4'd3;
	localparam logic [3:0] PH_BUSY_HI = 4'd4;
	localparam logic [3:0] PH_READ    = 4'd5;
	localparam logic [3:0] PH_RELEASE = 4'd6;

	typedef struct packed {
		logic [1:0]  rotation;
		logic [11:0] x_offset;
		logic [15:0] x_scale;
		logic [11:0] y_offset;
		logic [15:0] y_scale;
		logic [9:0]  wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic               chip_select_n;
		logic               serial_clock;
		logic               mosi_out;
		logic               sample_done;
		logic [COORD_W-1:0] touch_x;
		logic [COORD_W-1:0] touch_y;
	} tick_out_t;

endpackage

`default_nettype wire

/* src/touch_panel_reader_unit.sv */
// Touch panel reader: one input transfer is one half-bit tick of the serial
// link, carrying the pen interrupt level and the sampled data line. Every
// tick yields exactly one output transfer with the chip select, serial clock
// and command levels to drive for that tick, a sample_done flag and the
// rotated touch coordinate of the last completed sample.
// A tick is registered in the input register on acceptance and its result
// is registered in the result register, from which it is offered to the
// receiver and can be taken. The block takes one tick per cycle while the
// receiver does not stall; a single sequencer update lies between the input
// register and the result register.
// A full sample takes 2 x (16 + wait_ticks + 2 + 32 + 1) ticks after the
// idle tick that sees the pen down.
// Configuration writes are always ready and take effect at once; they are
// to be made only while no tick is in flight.
// Reset restores the default calibration, returns the sequencer to idle and
// empties both registers. When the receiver stalls, the result is held and
// in_stall rises in the same cycle, so no tick is lost.
`default_nettype none
`include "assert_macros.svh"

module touch_panel_reader_unit import tpr_pkg::*; #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 480
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  pen_irq_n,
	input  wire logic                  miso_in,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       chip_select_n,
	output logic                       serial_clock,
	output logic                       mosi_out,
	output logic                       sample_done,
	output logic      [COORD_W-1:0]    touch_x,
	output logic      [COORD_W-1:0]    touch_y,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(MAX_DIM);

	cfg_t      cfg_q;
	logic      valid_s1;
	logic      pen_s1;
	logic      miso_s1;
	logic      valid_s2;
	tick_out_t res_s2;
	tick_out_t seq_res;
	logic      enable;
	logic      coord_over;

	assign enable    = !valid_s2 || !out_stall;
	assign in_stall  = !enable;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation   <= RESET_ROTATION;
			cfg_q.x_offset   <= RESET_X_OFFSET;
			cfg_q.x_scale    <= RESET_X_SCALE;
			cfg_q.y_offset   <= RESET_Y_OFFSET;
			cfg_q.y_scale    <= RESET_Y_SCALE;
			cfg_q.wait_ticks <= RESET_WAIT_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROTATION:   cfg_q.rotation   <= cfg_data[1:0];
				REG_X_OFFSET:   cfg_q.x_offset   <= cfg_data[11:0];
				REG_X_SCALE:    cfg_q.x_scale    <= cfg_data;
				REG_Y_OFFSET:   cfg_q.y_offset   <= cfg_data[11:0];
				REG_Y_SCALE:    cfg_q.y_scale    <= cfg_data;
				REG_WAIT_TICKS: cfg_q.wait_ticks <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (enable) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (enable && in_valid) begin
			pen_s1  <= pen_irq_n;
			miso_s1 <= miso_in;
		end
		if (enable && valid_s1) begin
			res_s2 <= seq_res;
		end
	end

	tpr_seq #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (enable && valid_s1),
		.pen_n   (pen_s1),
		.miso    (miso_s1),
		.cfg     (cfg_q),
		.result  (seq_res)
	);

	assign out_valid     = valid_s2;
	assign chip_select_n = res_s2.chip_select_n;
	assign serial_clock  = res_s2.serial_clock;
	assign mosi_out      = res_s2.mosi_out;
	assign sample_done   = res_s2.sample_done;
	assign touch_x       = res_s2.touch_x;
	assign touch_y       = res_s2.touch_y;
	assign coord_over    = (touch_x > MAX_COORD) || (touch_y > MAX_COORD);

	`TPR_ASSERT_IMP(a_done_deselects, out_valid && sample_done, chip_select_n, "done while selected")
	`TPR_ASSERT_IMP(a_quiet_mosi, out_valid && chip_select_n, !mosi_out, "command bit while deselected")
	`TPR_ASSERT_NEVER(a_coord_range, out_valid && coord_over, "touch coordinate beyond screen")

endmodule

`default_nettype wire

/* src/tpr_calib.sv */
`default_nettype none

module tpr_calib import tpr_pkg::*; #(
	parameter int SIZE = 320
) (
	input  wire logic [11:0]        raw,
	input  wire logic [11:0]        offset,
	input  wire logic [15:0]        scale,
	output logic      [COORD_W-1:0] pixel
);

	localparam logic [12:0] SIZE_W = 13'(SIZE);

	logic [12:0] diff;
	logic        positive;
	logic [27:0] product;
	logic [28:0] rounded;
	logic [12:0] correction;

	// A non-positive product means the correction is zero or negative, which
	// clamps the result to the full size.
	always_comb begin
		diff       = {1'b0, raw} - {1'b0, offset};
		positive   = !diff[12] && (diff != 13'd0) && (scale != 16'd0);
		product    = diff[11:0] * scale;
		rounded    = {1'b0, product} + 29'd65535;
		correction = rounded[28:16];
		if (!positive) begin
			pixel = SIZE_W[COORD_W-1:0];
		end else if (correction >= SIZE_W) begin
			pixel = '0;
		end else begin
			pixel = COORD_W'(SIZE_W - correction);
		end
	end

endmodule

`default_nettype wire

/* src/tpr_seq.sv */
`default_nettype none

module tpr_seq import tpr_pkg::*; #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 480
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire logic      pen_n,
	input  wire logic      miso,
	input  wire cfg_t      cfg,
	output tick_out_t      result
);

	localparam logic [COORD_W-1:0] W9 = COORD_W'(SCREEN_WIDTH);
	localparam logic [COORD_W-1:0] H9 = COORD_W'(SCREEN_HEIGHT);

	logic [3:0]         phase_q, phase_d;
	logic [4:0]         bit_count_q, bit_count_d;
	logic [9:0]         wait_count_q, wait_count_d;
	logic [15:0]        shift_q, shift_d;
	logic [11:0]        raw_x_q, raw_x_d;
	logic               axis_q, axis_d;
	logic [COORD_W-1:0] coord_x_q, coord_x_d;
	logic [COORD_W-1:0] coord_y_q, coord_y_d;
	logic [COORD_W-1:0] cal_x, cal_y;
	logic [7:0]         cmd;

	tpr_calib #(.SIZE(SCREEN_WIDTH)) u_calib_x (
		.raw    (raw_x_q),
		.offset (cfg.x_offset),
		.scale  (cfg.x_scale),
		.pixel  (cal_x)
	);

	tpr_calib #(.SIZE(SCREEN_HEIGHT)) u_calib_y (
		.raw    (shift_q[15:4]),
		.offset (cfg.y_offset),
		.scale  (cfg.y_scale),
		.pixel  (cal_y)
	);

	always_comb begin
		phase_d       = phase_q;
		bit_count_d   = bit_count_q;
		wait_count_d  = wait_count_q;
		shift_d       = shift_q;
		raw_x_d       = raw_x_q;
		axis_d        = axis_q;
		coord_x_d     = coord_x_q;
		coord_y_d     = coord_y_q;
		cmd           = axis_q ? CMD_CONV_Y : CMD_CONV_X;
		result        = '0;
		result.serial_clock = 1'b1;
		unique case (phase_q)
			PH_CMD: begin
				result.serial_clock = bit_count_q[0];
				result.mosi_out     = cmd[~bit_count_q[3:1]];
				if (bit_count_q >= 5'd15) begin
					bit_count_d  = '0;
					wait_count_d = '0;
					phase_d      = (cfg.wait_ticks != 10'd0) ? PH_WAIT : PH_BUSY_LO;
				end else begin
					bit_count_d = bit_count_q + 5'd1;
				end
			end
			PH_WAIT: begin
				wait_count_d = wait_count_q + 10'd1;
				if (wait_count_d >= cfg.wait_ticks) begin
					phase_d = PH_BUSY_LO;
				end
			end
			PH_BUSY_LO: begin
				result.serial_clock = 1'b0;
				phase_d             = PH_BUSY_HI;
			end
			PH_BUSY_HI: begin
				phase_d     = PH_READ;
				bit_count_d = '0;
				shift_d     = '0;
			end
			PH_READ: begin
				result.serial_clock = bit_count_q[0];
				if (bit_count_q[0]) begin
					shift_d = {shift_q[14:0], miso};
				end
				if (bit_count_q >= 5'd31) begin
					bit_count_d = '0;
					phase_d     = PH_RELEASE;
				end else begin
					bit_count_d = bit_count_q + 5'd1;
				end
			end
			PH_RELEASE: begin
				result.chip_select_n = 1'b1;
				if (!axis_q) begin
					raw_x_d     = shift_q[15:4];
					axis_d      = 1'b1;
					bit_count_d = '0;
					phase_d     = PH_CMD;
				end else begin
					case (cfg.rotation)
						ROT_0: begin
							coord_x_d = W9 - cal_x;
							coord_y_d = cal_y;
						end
						ROT_90: begin
							coord_x_d = cal_y;
							coord_y_d = cal_x;
						end
						ROT_180: begin
							coord_x_d = cal_x;
							coord_y_d = H9 - cal_y;
						end
						default: begin
							coord_x_d = H9 - cal_y;
							coord_y_d = W9 - cal_x;
						end
					endcase
					axis_d             = 1'b0;
					result.sample_done = 1'b1;
					phase_d            = PH_IDLE;
				end
			end
			default: begin
				result.chip_select_n = 1'b1;
				phase_d              = PH_IDLE;
				if (!pen_n) begin
					phase_d     = PH_CMD;
					bit_count_d = '0;
					axis_d      = 1'b0;
				end
			end
		endcase
		result.touch_x = coord_x_d;
		result.touch_y = coord_y_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			wait_count_q <= '0;
			shift_q      <= '0;
			raw_x_q      <= '0;
			axis_q       <= 1'b0;
			coord_x_q    <= '0;
			coord_y_q    <= '0;
		end else if (advance) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			wait_count_q <= wait_count_d;
			shift_q      <= shift_d;
			raw_x_q      <= raw_x_d;
			axis_q       <= axis_d;
			coord_x_q    <= coord_x_d;
			coord_y_q    <= coord_y_d;
		end
	end

endmodule

`default_nettype wire
